// ===== hw/rtl/gvde_pkg.sv =====
package gvde_pkg;

	// Number of cells in the evaluation row, one per share.
	localparam int MAX_SHARES = 16;
	// Index into the chunk store.
	localparam int IDX_W = $clog2(MAX_SHARES);
	// Counts that must also hold MAX_SHARES itself.
	localparam int CNT_W = $clog2(MAX_SHARES + 1);

	// Field and register widths.
	localparam int BYTE_W = 8;
	localparam int SHARE_W = 5;
	localparam int REG_W = 5;
	localparam int APB_ADDR_W = 3;
	localparam int APB_DATA_W = 32;

	// GF(256) reduction polynomial and its top bit.
	localparam logic [8:0] GF_POLY = 9'h11D;
	localparam logic [7:0] GF_TOP = 8'h80;

	// Register reset values.
	localparam logic [REG_W-1:0] SHARE_COUNT_RST = 5'd2;
	localparam logic [REG_W-1:0] CHUNK_SIZE_RST = 5'd1;

	// Register index, taken from paddr[2].
	typedef enum logic {
		REG_SHARE_COUNT = 1'b0,
		REG_CHUNK_SIZE  = 1'b1
	} reg_idx_t;

	// Controller states.
	typedef enum logic [1:0] {
		ST_GATHER,
		ST_COMPUTE,
		ST_EMIT
	} state_t;

	// Commands broadcast to every cell of the row.
	typedef struct packed {
		logic load;
		logic step;
		logic shift;
	} cell_ctrl_t;

	// GF(256) multiply, shift and add over the eight bits of b.
	function automatic logic [7:0] gf_mul(input logic [7:0] a, input logic [7:0] b);
		logic [7:0] acc;
		logic [7:0] x;
		acc = '0;
		x = a;
		for (int i = 0; i < 8; i++) begin
			if (b[i]) begin
				acc = acc ^ x;
			end
			if ((x & GF_TOP) != 8'h00) begin
				x = (x << 1) ^ GF_POLY[7:0];
			end else begin
				x = x << 1;
			end
		end
		return acc;
	endfunction

endpackage

// ===== hw/rtl/gvde_in_if.sv =====
interface gvde_in_if;
	logic                        valid;
	logic                        ready;
	logic [gvde_pkg::BYTE_W-1:0] data_byte;
	logic                        end_of_data;

	modport source (output valid, output data_byte, output end_of_data, input ready);
	modport sink (input valid, input data_byte, input end_of_data, output ready);
endinterface

// ===== hw/rtl/gvde_out_if.sv =====
interface gvde_out_if;
	logic                         valid;
	logic                         ready;
	logic [gvde_pkg::BYTE_W-1:0]  share_byte;
	logic [gvde_pkg::SHARE_W-1:0] share_number;
	logic                         last;

	modport source (output valid, output share_byte, output share_number, output last,
		input ready);
	modport sink (input valid, input share_byte, input share_number, input last,
		output ready);
endinterface

// ===== hw/rtl/gvde_apb_regs.sv =====
module gvde_apb_regs (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                psel,
	input  logic                                penable,
	input  logic                                pwrite,
	input  logic [gvde_pkg::APB_ADDR_W-1:0]     paddr,
	input  logic [gvde_pkg::APB_DATA_W-1:0]     pwdata,
	output logic [gvde_pkg::APB_DATA_W-1:0]     prdata,
	output logic                                pready,
	output logic [gvde_pkg::CNT_W-1:0]          n_eff,
	output logic [gvde_pkg::CNT_W-1:0]          k_eff
);

	logic [gvde_pkg::REG_W-1:0] share_count_q;
	logic [gvde_pkg::REG_W-1:0] chunk_size_q;
	gvde_pkg::reg_idx_t         reg_idx;
	logic                       wr_en;
	logic [gvde_pkg::CNT_W-1:0] k_raw;

	assign pready = 1'b1;
	assign reg_idx = gvde_pkg::reg_idx_t'(paddr[2]);
	assign wr_en = psel && penable && pwrite;

	// Register writes on the access cycle.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			share_count_q <= gvde_pkg::SHARE_COUNT_RST;
			chunk_size_q <= gvde_pkg::CHUNK_SIZE_RST;
		end else if (wr_en) begin
			unique case (reg_idx)
				gvde_pkg::REG_SHARE_COUNT: share_count_q <= pwdata[gvde_pkg::REG_W-1:0];
				gvde_pkg::REG_CHUNK_SIZE:  chunk_size_q <= pwdata[gvde_pkg::REG_W-1:0];
				default: ;
			endcase
		end
	end

	// Read back the stored register values.
	always_comb begin
		prdata = '0;
		unique case (reg_idx)
			gvde_pkg::REG_SHARE_COUNT: prdata[gvde_pkg::REG_W-1:0] = share_count_q;
			gvde_pkg::REG_CHUNK_SIZE:  prdata[gvde_pkg::REG_W-1:0] = chunk_size_q;
			default: prdata = '0;
		endcase
	end

	// Share count saturates to 1..MAX_SHARES, chunk size to 1..n.
	always_comb begin
		if (share_count_q == '0) begin
			n_eff = gvde_pkg::CNT_W'(1);
		end else if (share_count_q > gvde_pkg::CNT_W'(gvde_pkg::MAX_SHARES)) begin
			n_eff = gvde_pkg::CNT_W'(gvde_pkg::MAX_SHARES);
		end else begin
			n_eff = share_count_q;
		end
		k_raw = (chunk_size_q == '0) ? gvde_pkg::CNT_W'(1) : chunk_size_q;
		k_eff = (k_raw > n_eff) ? n_eff : k_raw;
	end

endmodule

// ===== hw/rtl/gvde_cell.sv =====
module gvde_cell (
	input  logic                        clk,
	input  logic [gvde_pkg::BYTE_W-1:0] x,
	input  gvde_pkg::cell_ctrl_t        ctrl,
	input  logic [gvde_pkg::BYTE_W-1:0] din,
	input  logic [gvde_pkg::BYTE_W-1:0] next_acc,
	output logic [gvde_pkg::BYTE_W-1:0] acc
);

	logic [gvde_pkg::BYTE_W-1:0] acc_q;

	// One Horner step per cycle, acc = acc * x + byte, a load of the first byte, or a shift toward the head.
	always_ff @(posedge clk) begin
		if (ctrl.load) begin
			acc_q <= din;
		end else if (ctrl.step) begin
			acc_q <= gvde_pkg::gf_mul(acc_q, x) ^ din;
		end else if (ctrl.shift) begin
			acc_q <= next_acc;
		end
	end

	assign acc = acc_q;

endmodule

// ===== hw/rtl/gvde_ctrl.sv =====
module gvde_ctrl (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic [gvde_pkg::CNT_W-1:0]    n_eff,
	input  logic [gvde_pkg::CNT_W-1:0]    k_eff,
	input  logic                          in_valid,
	input  logic [gvde_pkg::BYTE_W-1:0]   in_byte,
	input  logic                          in_eod,
	output logic                          in_ready,
	input  logic                          out_ready,
	output logic                          out_valid,
	output logic [gvde_pkg::SHARE_W-1:0]  share_number,
	output logic                          last,
	output gvde_pkg::cell_ctrl_t          cell_ctrl,
	output logic [gvde_pkg::BYTE_W-1:0]   cell_din
);

	gvde_pkg::state_t            state_q;
	gvde_pkg::state_t            state_d;
	logic [gvde_pkg::BYTE_W-1:0] store_q [gvde_pkg::MAX_SHARES];
	logic [gvde_pkg::BYTE_W-1:0] rd_q;
	logic [gvde_pkg::CNT_W-1:0]  fill_q;
	logic [gvde_pkg::CNT_W-1:0]  fill_nx;
	logic [gvde_pkg::CNT_W-1:0]  used;
	logic [gvde_pkg::IDX_W-1:0]  idx_q;
	logic [gvde_pkg::SHARE_W-1:0] sn_q;
	logic                        pend_q;
	logic                        first_q;
	logic                        in_fire;
	logic                        out_fire;
	logic                        trig;
	logic                        store_room;

	// Chunk fill bookkeeping for the item on the input.
	always_comb begin
		store_room = fill_q < gvde_pkg::CNT_W'(gvde_pkg::MAX_SHARES);
		fill_nx = store_room ? fill_q + gvde_pkg::CNT_W'(1) : fill_q;
		trig = in_eod || (fill_nx >= k_eff);
		used = (fill_nx < k_eff) ? fill_nx : k_eff;
	end

	assign in_fire = in_valid && in_ready;
	assign out_fire = out_valid && out_ready;
	assign share_number = sn_q;
	assign last = (sn_q == gvde_pkg::SHARE_W'(n_eff));
	assign cell_din = rd_q;

	// State register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= gvde_pkg::ST_GATHER;
		end else begin
			state_q <= state_d;
		end
	end

	// Next state and handshake outputs.
	always_comb begin
		state_d = state_q;
		in_ready = 1'b0;
		out_valid = 1'b0;
		cell_ctrl = '0;
		unique case (state_q)
			gvde_pkg::ST_GATHER: begin
				in_ready = 1'b1;
				if (in_valid && trig) begin
					state_d = gvde_pkg::ST_COMPUTE;
				end
			end
			gvde_pkg::ST_COMPUTE: begin
				cell_ctrl.load = first_q;
				cell_ctrl.step = !first_q;
				if (idx_q == '0) begin
					state_d = gvde_pkg::ST_EMIT;
				end
			end
			gvde_pkg::ST_EMIT: begin
				in_ready = !pend_q;
				out_valid = 1'b1;
				cell_ctrl.shift = out_ready;
				if (out_ready && last) begin
					if (pend_q || (in_fire && trig)) begin
						state_d = gvde_pkg::ST_COMPUTE;
					end else begin
						state_d = gvde_pkg::ST_GATHER;
					end
				end
			end
			default: state_d = gvde_pkg::ST_GATHER;
		endcase
	end

	// Fill count, chunk start index, share counter, first-byte flag and pending chunk flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q <= '0;
			idx_q <= '0;
			sn_q <= '0;
			pend_q <= 1'b0;
			first_q <= 1'b0;
		end else begin
			if (in_fire) begin
				fill_q <= trig ? '0 : fill_nx;
				if (trig) begin
					idx_q <= gvde_pkg::IDX_W'(used - gvde_pkg::CNT_W'(1));
					first_q <= 1'b1;
				end
			end
			if (state_q == gvde_pkg::ST_COMPUTE) begin
				first_q <= 1'b0;
				if (idx_q == '0) begin
					sn_q <= gvde_pkg::SHARE_W'(1);
				end else begin
					idx_q <= idx_q - gvde_pkg::IDX_W'(1);
				end
			end
			if (state_q == gvde_pkg::ST_EMIT) begin
				if (out_fire && last) begin
					pend_q <= 1'b0;
				end else if (in_fire && trig) begin
					pend_q <= 1'b1;
				end
				if (out_fire && !last) begin
					sn_q <= sn_q + gvde_pkg::SHARE_W'(1);
				end
			end
		end
	end

	// Chunk store; a byte that finds the store full is dropped. The read register
	// holds the byte the row takes next, and a byte written in the same cycle
	// comes straight from the input.
	always_ff @(posedge clk) begin
		if (in_fire && store_room) begin
			store_q[fill_q[gvde_pkg::IDX_W-1:0]] <= in_byte;
		end
		if (in_fire && trig) begin
			if (store_room && (used == fill_nx)) begin
				rd_q <= in_byte;
			end else begin
				rd_q <= store_q[gvde_pkg::IDX_W'(used - gvde_pkg::CNT_W'(1))];
			end
		end else if ((state_q == gvde_pkg::ST_COMPUTE) && (idx_q != '0)) begin
			rd_q <= store_q[idx_q - gvde_pkg::IDX_W'(1)];
		end
	end

endmodule

// ===== hw/rtl/gf256_vandermonde_dispersal_encoder.sv =====
// Rabin-style dispersal encoder over GF(256), polynomial 0x11D. Data bytes are
// gathered into chunks of k bytes (chunk_size, clamped to 1..n); a full chunk,
// or a byte marked end_of_data, is encoded into n share bytes (share_count,
// clamped to 1..16), share r carrying the sum of r^c times byte c, sent in
// order r = 1..n with last set on share n. Bytes arrive one per cycle while
// gathering. The encode runs Horner's rule in a row of 16 cells, one per share,
// one chunk byte per cycle; the same row then shifts the n results out through
// its head cell, one per cycle while the receiver is ready. Bytes of the next
// chunk are taken while results go out. Registers sit at byte address 0
// (share_count) and 4 (chunk_size); the user must see that they are written only
// while the encoder is idle, as the block itself does not enforce it. The chunk
// store needs no clearing after reset.
module gf256_vandermonde_dispersal_encoder (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            psel,
	input  logic                            penable,
	input  logic                            pwrite,
	input  logic [gvde_pkg::APB_ADDR_W-1:0] paddr,
	input  logic [gvde_pkg::APB_DATA_W-1:0] pwdata,
	output logic [gvde_pkg::APB_DATA_W-1:0] prdata,
	output logic                            pready,
	gvde_in_if.sink                         data_stream,
	gvde_out_if.source                      share_stream
);

	logic [gvde_pkg::CNT_W-1:0]  n_eff;
	logic [gvde_pkg::CNT_W-1:0]  k_eff;
	gvde_pkg::cell_ctrl_t        cell_ctrl;
	logic [gvde_pkg::BYTE_W-1:0] cell_din;
	logic [gvde_pkg::BYTE_W-1:0] acc [gvde_pkg::MAX_SHARES];

	// Configuration registers.
	gvde_apb_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.n_eff   (n_eff),
		.k_eff   (k_eff)
	);

	// Gathering, sequencing and output handshake.
	gvde_ctrl u_ctrl (
		.clk          (clk),
		.arst_n       (arst_n),
		.n_eff        (n_eff),
		.k_eff        (k_eff),
		.in_valid     (data_stream.valid),
		.in_byte      (data_stream.data_byte),
		.in_eod       (data_stream.end_of_data),
		.in_ready     (data_stream.ready),
		.out_ready    (share_stream.ready),
		.out_valid    (share_stream.valid),
		.share_number (share_stream.share_number),
		.last         (share_stream.last),
		.cell_ctrl    (cell_ctrl),
		.cell_din     (cell_din)
	);

	// Row of evaluation cells; cell i evaluates at x = i + 1.
	for (genvar i = 0; i < gvde_pkg::MAX_SHARES; i++) begin : g_cell
		logic [gvde_pkg::BYTE_W-1:0] next_acc;
		if (i == gvde_pkg::MAX_SHARES - 1) begin : g_tail
			assign next_acc = '0;
		end else begin : g_link
			assign next_acc = acc[i+1];
		end
		gvde_cell u_cell (
			.clk      (clk),
			.x        (gvde_pkg::BYTE_W'(i + 1)),
			.ctrl     (cell_ctrl),
			.din      (cell_din),
			.next_acc (next_acc),
			.acc      (acc[i])
		);
	end

	assign share_stream.share_byte = acc[0];

endmodule

// ===== hw/rtl/gvde_checker.sv =====
module gvde_checker (
	input logic                         clk,
	input logic                         arst_n,
	input logic                         pready,
	input logic                         out_valid,
	input logic                         out_ready,
	input logic [gvde_pkg::BYTE_W-1:0]  share_byte,
	input logic [gvde_pkg::SHARE_W-1:0] share_number,
	input logic                         last
);

	// A stalled result holds its value.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(share_byte)
			&& $stable(share_number) && $stable(last))
		else $error("stalled share item changed");

	// Shares of one chunk follow each other with rising numbers.
	a_share_seq: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_ready && !last |=> out_valid
			&& share_number == $past(share_number) + gvde_pkg::SHARE_W'(1))
		else $error("share number did not advance by one");

	// Share numbers stay in range, from one up to MAX_SHARES.
	a_share_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> share_number != '0
			&& share_number <= gvde_pkg::SHARE_W'(gvde_pkg::MAX_SHARES))
		else $error("share number out of range");

	// In the cycle after the last share is taken, no share is offered.
	a_gap_after_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_ready && last |=> !out_valid)
		else $error("share item right after last");

	// The register port never inserts wait states.
	a_pready: assert property (@(posedge clk) disable iff (!arst_n) pready)
		else $error("pready low");

endmodule

bind gf256_vandermonde_dispersal_encoder gvde_checker u_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.pready       (pready),
	.out_valid    (share_stream.valid),
	.out_ready    (share_stream.ready),
	.share_byte   (share_stream.share_byte),
	.share_number (share_stream.share_number),
	.last         (share_stream.last)
);

// ===== verif/tb.sv =====
`timescale 1ns / 1ps

module tb;

	localparam int HALF_PERIOD = 6;
	localparam int SETTLE_CYCLES = 4 * gvde_pkg::MAX_SHARES;
	localparam int LONG_HOLD_CYCLES = 400;
	localparam int WATCHDOG_LIMIT = 3000;
	localparam int NUM_PHASES = 8;
	localparam int ITEMS_PER_PHASE = 25;
	localparam int REPORT_LIMIT = 10;

	// One share byte as it leaves the encoder.
	typedef struct packed {
		logic [gvde_pkg::BYTE_W-1:0]  share_byte;
		logic [gvde_pkg::SHARE_W-1:0] share_number;
		logic                         last;
	} share_result_t;

	// Keeps its own copy of the chunk and registers, encodes each finished
	// chunk into share bytes and checks the encoder output against them.
	class dispersal_scoreboard;
		logic [gvde_pkg::REG_W-1:0]  share_count_reg;
		logic [gvde_pkg::REG_W-1:0]  chunk_size_reg;
		logic [gvde_pkg::BYTE_W-1:0] gathered[gvde_pkg::MAX_SHARES];
		int unsigned                 fill;
		share_result_t               share_bytes_due[$];
		int unsigned                 errors;

		function new();
			share_count_reg = gvde_pkg::SHARE_COUNT_RST;
			chunk_size_reg = gvde_pkg::CHUNK_SIZE_RST;
			fill = 0;
			errors = 0;
		endfunction

		function void set_register(gvde_pkg::reg_idx_t idx,
			logic [gvde_pkg::REG_W-1:0] value);
			case (idx)
				gvde_pkg::REG_SHARE_COUNT: share_count_reg = value;
				gvde_pkg::REG_CHUNK_SIZE: chunk_size_reg = value;
				default: ;
			endcase
		endfunction

		function int unsigned pending();
			return share_bytes_due.size();
		endfunction

		// Shift-and-add product in GF(256).
		function logic [gvde_pkg::BYTE_W-1:0] gf_times(logic [gvde_pkg::BYTE_W-1:0] a,
			logic [gvde_pkg::BYTE_W-1:0] b);
			logic [gvde_pkg::BYTE_W-1:0] sum;
			logic [gvde_pkg::BYTE_W-1:0] addend;
			sum = '0;
			addend = a;
			for (int i = 0; i < gvde_pkg::BYTE_W; i++) begin
				if (b[i]) begin
					sum = sum ^ addend;
				end
				addend = {addend[gvde_pkg::BYTE_W-2:0], 1'b0}
					^ (addend[gvde_pkg::BYTE_W-1] ? gvde_pkg::GF_POLY[7:0] : 8'h00);
			end
			return sum;
		endfunction

		// Gathers one data byte; a full or marked chunk turns into n share bytes.
		function void take_data_byte(logic [gvde_pkg::BYTE_W-1:0] data, logic eod);
			int unsigned   n;
			int unsigned   k;
			int unsigned   used;
			logic [7:0]    point;
			logic [7:0]    power;
			logic [7:0]    acc;
			share_result_t res;
			n = share_count_reg;
			if (n < 1) n = 1;
			if (n > gvde_pkg::MAX_SHARES) n = gvde_pkg::MAX_SHARES;
			k = chunk_size_reg;
			if (k < 1) k = 1;
			if (k > n) k = n;
			if (fill < gvde_pkg::MAX_SHARES) begin
				gathered[gvde_pkg::IDX_W'(fill)] = data;
				fill++;
			end
			if (fill < k && !eod) begin
				return;
			end
			// A short chunk counts as zero-padded, so only the gathered bytes add in.
			used = (fill < k) ? fill : k;
			for (int unsigned r = 1; r <= n; r++) begin
				point = 8'(r);
				power = 8'h01;
				acc = 8'h00;
				for (int unsigned c = 0; c < used; c++) begin
					acc = acc ^ gf_times(power, gathered[gvde_pkg::IDX_W'(c)]);
					power = gf_times(power, point);
				end
				res.share_byte = acc;
				res.share_number = gvde_pkg::SHARE_W'(r);
				res.last = (r == n);
				share_bytes_due = {share_bytes_due, res};
			end
			fill = 0;
		endfunction

		function void report(string what, int unsigned want, int unsigned got);
			errors++;
			if (errors <= REPORT_LIMIT) begin
				$display("%0t: %s expected %0h got %0h", $time, what, want, got);
			end
		endfunction

		function void check_share(share_result_t got);
			share_result_t want;
			if (share_bytes_due.size() == 0) begin
				errors++;
				if (errors <= REPORT_LIMIT) begin
					$display("%0t: share byte %0h for share %0d arrived with none due",
						$time, got.share_byte, got.share_number);
				end
				return;
			end
			want = share_bytes_due.pop_front();
			if (got.share_byte !== want.share_byte) begin
				report("share_byte", want.share_byte, got.share_byte);
			end
			if (got.share_number !== want.share_number) begin
				report("share_number", want.share_number, got.share_number);
			end
			if (got.last !== want.last) begin
				report("last", want.last, got.last);
			end
		endfunction
	endclass

	logic                            clk;
	logic                            arst_n;
	logic                            psel;
	logic                            penable;
	logic                            pwrite;
	logic [gvde_pkg::APB_ADDR_W-1:0] paddr;
	logic [gvde_pkg::APB_DATA_W-1:0] pwdata;
	logic [gvde_pkg::APB_DATA_W-1:0] prdata;
	logic                            pready;

	gvde_in_if  data_if ();
	gvde_out_if share_if ();

	dispersal_scoreboard sb;
	bit                  quiet;
	bit                  hold_long;
	int unsigned         stalled_cycles;

	gf256_vandermonde_dispersal_encoder u_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.psel         (psel),
		.penable      (penable),
		.pwrite       (pwrite),
		.paddr        (paddr),
		.pwdata       (pwdata),
		.prdata       (prdata),
		.pready       (pready),
		.data_stream  (data_if),
		.share_stream (share_if)
	);

	always begin
		clk = 1'b0;
		#HALF_PERIOD;
		clk = 1'b1;
		#HALF_PERIOD;
	end

	// Watch both channels; inputs are noted before results are checked.
	always @(posedge clk) begin
		if (arst_n) begin
			if (data_if.valid && data_if.ready) begin
				sb.take_data_byte(data_if.data_byte, data_if.end_of_data);
			end
			if (share_if.valid && share_if.ready) begin
				sb.check_share('{share_if.share_byte, share_if.share_number, share_if.last});
			end
		end
	end

	// End the run if neither channel moves an item for too long.
	always @(posedge clk) begin
		if ((data_if.valid && data_if.ready) || (share_if.valid && share_if.ready)) begin
			stalled_cycles = 0;
		end else begin
			stalled_cycles++;
		end
		if (stalled_cycles >= WATCHDOG_LIMIT) begin
			$display("Mismatches found");
			$finish;
		end
	end

	// Share receiver: random stall bursts, one long hold on request.
	initial begin
		share_if.ready <= 1'b0;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			if (hold_long) begin
				share_if.ready <= 1'b0;
				repeat (LONG_HOLD_CYCLES) @(posedge clk);
				hold_long = 1'b0;
			end else if (!quiet && $urandom_range(0, 5) == 0) begin
				share_if.ready <= 1'b0;
				repeat ($urandom_range(1, 17)) @(posedge clk);
			end else begin
				share_if.ready <= 1'b1;
				@(posedge clk);
			end
		end
	end

	// Offer one data byte, sometimes after a gap, and wait until it is taken.
	task automatic send_byte(input logic [gvde_pkg::BYTE_W-1:0] data, input logic eod);
		if (!quiet && $urandom_range(0, 3) == 0) begin
			data_if.valid <= 1'b0;
			repeat ($urandom_range(1, 17)) @(posedge clk);
		end
		data_if.valid <= 1'b1;
		data_if.data_byte <= data;
		data_if.end_of_data <= eod;
		do @(posedge clk); while (!data_if.ready);
	endtask

	// Stop sending, wait for every due share byte, then let the encoder drain.
	// The first edge lets the monitor note the last accepted byte.
	task automatic settle_block();
		data_if.valid <= 1'b0;
		@(posedge clk);
		while (sb.pending() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// APB write: setup cycle, then access cycle until pready, then a return to idle.
	task automatic write_register(input gvde_pkg::reg_idx_t idx,
		input logic [gvde_pkg::REG_W-1:0] value);
		logic [gvde_pkg::APB_DATA_W-1:0] word;
		word = $urandom;
		word[gvde_pkg::REG_W-1:0] = value;
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= word;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		sb.set_register(idx, value);
		@(posedge clk);
	endtask

	task automatic configure(input logic [gvde_pkg::REG_W-1:0] shares,
		input logic [gvde_pkg::REG_W-1:0] chunk);
		settle_block();
		write_register(gvde_pkg::REG_SHARE_COUNT, shares);
		write_register(gvde_pkg::REG_CHUNK_SIZE, chunk);
	endtask

	initial begin
		logic [gvde_pkg::REG_W-1:0] shares;
		logic [gvde_pkg::REG_W-1:0] chunk;
		sb = new();
		quiet = 1'b0;
		hold_long = 1'b0;
		stalled_cycles = 0;
		arst_n <= 1'b0;
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		paddr <= '0;
		pwdata <= '0;
		data_if.valid <= 1'b0;
		data_if.data_byte <= '0;
		data_if.end_of_data <= 1'b0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Reset settings: two shares, one byte per chunk, extreme bytes.
		send_byte(8'h00, 1'b0);
		send_byte(8'hFF, 1'b0);

		// Zero share count and zero chunk size both act as one.
		configure(5'd0, 5'd0);
		send_byte(8'h5A, 1'b0);

		// Both registers above range; a short marked chunk is zero-padded.
		configure(5'd31, 5'd31);
		send_byte(8'hFF, 1'b0);
		send_byte(8'h80, 1'b0);
		send_byte(8'h01, 1'b1);

		// Chunk size above the share count is clamped to it.
		configure(5'd5, 5'd9);
		send_byte(8'hFF, 1'b0);
		send_byte(8'hFE, 1'b0);
		send_byte(8'h01, 1'b0);
		send_byte(8'h80, 1'b0);
		send_byte(8'h7F, 1'b0);

		// Unfinished chunk, then chunk size lowered under the bytes already held.
		configure(5'd8, 5'd8);
		for (int i = 0; i < 6; i++) begin
			send_byte(8'($urandom_range(0, 255)), 1'b0);
		end
		configure(5'd8, 5'd2);
		send_byte(8'($urandom_range(0, 255)), 1'b0);

		// End mark on the byte that fills the chunk.
		send_byte(8'($urandom_range(0, 255)), 1'b0);
		send_byte(8'($urandom_range(0, 255)), 1'b1);

		// Random streams over a range of settings; the last phase runs without idling.
		for (int p = 0; p < NUM_PHASES; p++) begin
			case (p)
				0: begin
					shares = 5'd16;
					chunk = 5'd1;
				end
				1: begin
					shares = 5'd16;
					chunk = 5'd16;
				end
				2: begin
					shares = 5'd1;
					chunk = 5'd16;
				end
				5: begin
					shares = 5'd4;
					chunk = 5'd2;
				end
				7: begin
					shares = 5'd16;
					chunk = 5'd3;
				end
				default: begin
					shares = 5'($urandom_range(0, 31));
					chunk = 5'($urandom_range(0, 31));
				end
			endcase
			configure(shares, chunk);
			quiet = (p == NUM_PHASES - 1);
			for (int i = 0; i < ITEMS_PER_PHASE; i++) begin
				// Each byte makes sixteen results here, so a long hold backs up the input.
				if (p == 0 && i == 4) begin
					hold_long = 1'b1;
				end
				if (p == 5 && i == 12) begin
					settle_block();
				end
				send_byte(8'($urandom_range(0, 255)), $urandom_range(0, 7) == 0);
			end
		end

		settle_block();
		if (sb.errors == 0 && sb.pending() == 0) begin
			$display("No mismatches found");
		end else begin
			$display("Mismatches found");
		end
		$finish;
	end

endmodule
